>>> rtl/core/slt_pkg.sv
// Shared types, token codes and keyword table for the source token lexer.
// Used by slt_lexer, slt_queue and source_token_lexer.
package slt_pkg;

    localparam int COUNT_BITS    = 16;
    localparam int KEYWORD_CHARS = 6;
    localparam int KW_BITS       = 8 * KEYWORD_CHARS;
    localparam int KW_COUNT      = 23;
    localparam int QUEUE_DEPTH   = 4;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    localparam logic [5:0] K_IDENT   = 6'd23;
    localparam logic [5:0] K_INT     = 6'd24;
    localparam logic [5:0] K_FLOAT   = 6'd25;
    localparam logic [5:0] K_STRING  = 6'd26;
    localparam logic [5:0] K_OP      = 6'd27;
    localparam logic [5:0] K_EQUALS  = 6'd28;
    localparam logic [5:0] K_DOT     = 6'd29;
    localparam logic [5:0] K_COLON   = 6'd30;
    localparam logic [5:0] K_COMMA   = 6'd31;
    localparam logic [5:0] K_LBRACE  = 6'd32;
    localparam logic [5:0] K_RBRACE  = 6'd33;
    localparam logic [5:0] K_LPAREN  = 6'd34;
    localparam logic [5:0] K_RPAREN  = 6'd35;
    localparam logic [5:0] K_LBRACK  = 6'd36;
    localparam logic [5:0] K_RBRACK  = 6'd37;
    localparam logic [5:0] K_NEWLINE = 6'd38;
    localparam logic [5:0] K_END     = 6'd39;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_BAD_BYTE = 3'd1;
    localparam logic [2:0] ST_OPEN_CMT = 3'd2;
    localparam logic [2:0] ST_OPEN_STR = 3'd3;
    localparam logic [2:0] ST_STRAY    = 3'd4;

    typedef enum logic [14:0] {
        M_IDLE  = 15'b000000000000001,
        M_WORD  = 15'b000000000000010,
        M_NUM   = 15'b000000000000100,
        M_FRAC  = 15'b000000000001000,
        M_DOTP  = 15'b000000000010000,
        M_STR   = 15'b000000000100000,
        M_SLASH = 15'b000000001000000,
        M_LCOMM = 15'b000000010000000,
        M_BCOMM = 15'b000000100000000,
        M_CMP   = 15'b000001000000000,
        M_BAR   = 15'b000010000000000,
        M_AMP   = 15'b000100000000000,
        M_EQ    = 15'b001000000000000,
        M_BSL   = 15'b010000000000000,
        M_DONE  = 15'b100000000000000
    } mode_t;

    typedef struct packed {
        logic [5:0]  kind;
        logic [2:0]  status;
        logic [15:0] line;
        logic [15:0] column;
        logic [15:0] length;
    } tok_t;

    typedef struct packed {
        logic [1:0] count;
        tok_t       first;
        tok_t       second;
    } push_t;

    typedef struct packed {
        tok_t tok;
        logic last;
    } entry_t;

    localparam logic [KW_BITS-1:0] KW_TEXT [KW_COUNT] = '{
        KW_BITS'("array"), KW_BITS'("assert"), KW_BITS'("bool"), KW_BITS'("else"),
        KW_BITS'("false"), KW_BITS'("float"), KW_BITS'("fn"), KW_BITS'("if"),
        KW_BITS'("image"), KW_BITS'("int"), KW_BITS'("let"), KW_BITS'("print"),
        KW_BITS'("read"), KW_BITS'("return"), KW_BITS'("show"), KW_BITS'("struct"),
        KW_BITS'("sum"), KW_BITS'("then"), KW_BITS'("time"), KW_BITS'("to"),
        KW_BITS'("true"), KW_BITS'("void"), KW_BITS'("write")
    };

    localparam logic [2:0] KW_LEN [KW_COUNT] = '{
        3'd5, 3'd6, 3'd4, 3'd4, 3'd5, 3'd5, 3'd2, 3'd2, 3'd5, 3'd3, 3'd3, 3'd5,
        3'd4, 3'd6, 3'd4, 3'd6, 3'd3, 3'd4, 3'd4, 3'd2, 3'd4, 3'd4, 3'd5
    };

    function automatic logic [5:0] word_kind(input logic [KW_BITS-1:0] prefix,
                                             input logic [COUNT_BITS-1:0] len);
        logic [5:0] k;
        k = K_IDENT;
        for (int i = KW_COUNT - 1; i >= 0; i--)
        begin
            if (len == COUNT_BITS'(KW_LEN[i]) && prefix == KW_TEXT[i])
            begin
                k = 6'(i);
            end
        end
        return k;
    endfunction

    function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
        return (v == COUNT_MAX) ? v : v + 1'b1;
    endfunction

    function automatic tok_t mk_tok(input logic [5:0] kind, input logic [2:0] status,
                                    input logic [COUNT_BITS-1:0] line,
                                    input logic [COUNT_BITS-1:0] column,
                                    input logic [COUNT_BITS-1:0] length);
        tok_t t;
        t.kind   = kind;
        t.status = status;
        t.line   = 16'(line);
        t.column = 16'(column);
        t.length = 16'(length);
        return t;
    endfunction

endpackage

>>> rtl/core/slt_lexer.sv
// Lexer state registers and per-byte next-state and token logic.
// Depends on slt_pkg.
module slt_lexer
    import slt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        accept,
    input  logic [7:0]  char_code,
    input  logic        end_of_input,
    output push_t       push
);

    mode_t                 mode_reg, mode_next;
    logic [COUNT_BITS-1:0] line_reg, line_next, col_reg, col_next;
    logic [COUNT_BITS-1:0] sline_reg, sline_next, scol_reg, scol_next;
    logic [COUNT_BITS-1:0] len_reg, len_next;
    logic [KW_BITS-1:0]    prefix_reg, prefix_next;
    logic                  dot_reg, dot_next, star_reg, star_next, nl_reg, nl_next;

    logic  p1_v, p2_v, do_begin, is_dig, is_let;
    tok_t  p1, p2;
    logic [7:0] c;

    always_comb
    begin
        c           = char_code;
        is_dig      = (c >= "0") && (c <= "9");
        is_let      = ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
        mode_next   = mode_reg;
        line_next   = line_reg;
        col_next    = col_reg;
        sline_next  = sline_reg;
        scol_next   = scol_reg;
        len_next    = len_reg;
        prefix_next = prefix_reg;
        dot_next    = dot_reg;
        star_next   = star_reg;
        nl_next     = nl_reg;
        p1_v        = 1'b0;
        p2_v        = 1'b0;
        p1          = '0;
        p2          = '0;
        do_begin    = 1'b0;
        if (accept && mode_reg != M_DONE)
        begin
            if (end_of_input)
            begin
                p1_v = 1'b1;
                case (mode_reg)
                    M_WORD:  p1 = mk_tok(word_kind(prefix_reg, len_reg), ST_OK,
                                         sline_reg, scol_reg, len_reg);
                    M_NUM:   p1 = mk_tok(dot_reg ? K_FLOAT : K_INT, ST_OK,
                                         sline_reg, scol_reg, len_reg);
                    M_FRAC:  p1 = mk_tok(K_FLOAT, ST_OK, sline_reg, scol_reg, len_reg);
                    M_DOTP:  p1 = mk_tok(K_DOT, ST_OK, sline_reg, scol_reg, len_reg);
                    M_SLASH, M_CMP:
                             p1 = mk_tok(K_OP, ST_OK, sline_reg, scol_reg, len_reg);
                    M_EQ:    p1 = mk_tok(K_EQUALS, ST_OK, sline_reg, scol_reg, len_reg);
                    M_STR:   p1 = mk_tok(K_END, ST_OPEN_STR, sline_reg, scol_reg, '0);
                    M_BCOMM: p1 = mk_tok(K_END, ST_OPEN_CMT, sline_reg, scol_reg, '0);
                    M_BAR, M_AMP, M_BSL:
                             p1 = mk_tok(K_END, ST_STRAY, sline_reg, scol_reg, '0);
                    default: p1_v = 1'b0;
                endcase
                if (p1_v && p1.status == ST_OK)
                begin
                    nl_next = 1'b0;
                end
                if (!(p1_v && p1.status != ST_OK))
                begin
                    p2_v = 1'b1;
                    p2   = mk_tok(K_END, ST_OK, line_reg, col_reg, '0);
                end
                mode_next = M_DONE;
            end
            else if ((c < 8'd32 || c > 8'd126) && c != 8'h0A)
            begin
                p1_v      = 1'b1;
                p1        = mk_tok(K_END, ST_BAD_BYTE, line_reg, col_reg, '0);
                mode_next = M_DONE;
            end
            else
            begin
                case (mode_reg)
                    M_WORD:
                    begin
                        if (is_let || is_dig || c == "_")
                        begin
                            if (len_reg < COUNT_BITS'(KEYWORD_CHARS))
                            begin
                                prefix_next = {prefix_reg[KW_BITS-9:0], c};
                            end
                            len_next = sat_inc(len_reg);
                        end
                        else
                        begin
                            p1_v     = 1'b1;
                            p1       = mk_tok(word_kind(prefix_reg, len_reg), ST_OK,
                                              sline_reg, scol_reg, len_reg);
                            do_begin = 1'b1;
                        end
                    end
                    M_NUM:
                    begin
                        if (is_dig)
                        begin
                            len_next = sat_inc(len_reg);
                        end
                        else if (c == ".")
                        begin
                            len_next = sat_inc(len_reg);
                            if (dot_reg)
                            begin
                                p1_v      = 1'b1;
                                p1        = mk_tok(K_FLOAT, ST_OK, sline_reg, scol_reg,
                                                   len_next);
                                mode_next = M_IDLE;
                            end
                            else
                            begin
                                dot_next = 1'b1;
                            end
                        end
                        else
                        begin
                            p1_v     = 1'b1;
                            p1       = mk_tok(dot_reg ? K_FLOAT : K_INT, ST_OK,
                                              sline_reg, scol_reg, len_reg);
                            do_begin = 1'b1;
                        end
                    end
                    M_FRAC:
                    begin
                        if (is_dig)
                        begin
                            len_next = sat_inc(len_reg);
                        end
                        else
                        begin
                            p1_v     = 1'b1;
                            p1       = mk_tok(K_FLOAT, ST_OK, sline_reg, scol_reg, len_reg);
                            do_begin = 1'b1;
                        end
                    end
                    M_DOTP:
                    begin
                        if (is_dig)
                        begin
                            mode_next = M_FRAC;
                            len_next  = COUNT_BITS'(2);
                        end
                        else
                        begin
                            p1_v     = 1'b1;
                            p1       = mk_tok(K_DOT, ST_OK, sline_reg, scol_reg, len_reg);
                            do_begin = 1'b1;
                        end
                    end
                    M_STR:
                    begin
                        if (c == 8'h0A)
                        begin
                            p1_v      = 1'b1;
                            p1        = mk_tok(K_END, ST_OPEN_STR, sline_reg, scol_reg, '0);
                            mode_next = M_DONE;
                        end
                        else
                        begin
                            len_next = sat_inc(len_reg);
                            if (c == "\"")
                            begin
                                p1_v      = 1'b1;
                                p1        = mk_tok(K_STRING, ST_OK, sline_reg, scol_reg,
                                                   len_next);
                                mode_next = M_IDLE;
                            end
                        end
                    end
                    M_SLASH:
                    begin
                        if (c == "/")
                        begin
                            mode_next = M_LCOMM;
                        end
                        else if (c == "*")
                        begin
                            mode_next = M_BCOMM;
                            star_next = 1'b0;
                        end
                        else
                        begin
                            p1_v     = 1'b1;
                            p1       = mk_tok(K_OP, ST_OK, sline_reg, scol_reg, len_reg);
                            do_begin = 1'b1;
                        end
                    end
                    M_LCOMM:
                    begin
                        do_begin = (c == 8'h0A);
                    end
                    M_BCOMM:
                    begin
                        if (c == "/" && star_reg)
                        begin
                            mode_next = M_IDLE;
                        end
                        else
                        begin
                            star_next = (c == "*");
                        end
                    end
                    M_CMP, M_EQ:
                    begin
                        p1_v = 1'b1;
                        if (c == "=")
                        begin
                            len_next  = COUNT_BITS'(2);
                            p1        = mk_tok(K_OP, ST_OK, sline_reg, scol_reg, len_next);
                            mode_next = M_IDLE;
                        end
                        else
                        begin
                            p1       = mk_tok((mode_reg == M_EQ) ? K_EQUALS : K_OP, ST_OK,
                                              sline_reg, scol_reg, len_reg);
                            do_begin = 1'b1;
                        end
                    end
                    M_BAR, M_AMP:
                    begin
                        p1_v = 1'b1;
                        if (c == ((mode_reg == M_BAR) ? 8'h7C : 8'h26))
                        begin
                            len_next  = COUNT_BITS'(2);
                            p1        = mk_tok(K_OP, ST_OK, sline_reg, scol_reg, len_next);
                            mode_next = M_IDLE;
                        end
                        else
                        begin
                            p1        = mk_tok(K_END, ST_STRAY, sline_reg, scol_reg, '0);
                            mode_next = M_DONE;
                        end
                    end
                    M_BSL:
                    begin
                        if (c == 8'h0A)
                        begin
                            mode_next = M_IDLE;
                        end
                        else
                        begin
                            p1_v      = 1'b1;
                            p1        = mk_tok(K_END, ST_STRAY, sline_reg, scol_reg, '0);
                            mode_next = M_DONE;
                        end
                    end
                    default: do_begin = 1'b1;
                endcase
                if (p1_v && p1.status == ST_OK)
                begin
                    nl_next = 1'b0;
                end
                if (do_begin)
                begin
                    sline_next = line_reg;
                    scol_next  = col_reg;
                    len_next   = COUNT_BITS'(1);
                    mode_next  = M_IDLE;
                    p2         = mk_tok(K_OP, ST_OK, line_reg, col_reg, COUNT_BITS'(1));
                    case (c)
                        8'h0A:
                        begin
                            p2.kind = K_NEWLINE;
                            p2_v    = !nl_next;
                        end
                        ":":  begin p2.kind = K_COLON;  p2_v = 1'b1; end
                        ",":  begin p2.kind = K_COMMA;  p2_v = 1'b1; end
                        "{":  begin p2.kind = K_LBRACE; p2_v = 1'b1; end
                        "}":  begin p2.kind = K_RBRACE; p2_v = 1'b1; end
                        "(":  begin p2.kind = K_LPAREN; p2_v = 1'b1; end
                        ")":  begin p2.kind = K_RPAREN; p2_v = 1'b1; end
                        "[":  begin p2.kind = K_LBRACK; p2_v = 1'b1; end
                        "]":  begin p2.kind = K_RBRACK; p2_v = 1'b1; end
                        "+", "-", "*", "%": p2_v = 1'b1;
                        " ":  ;
                        "\"": mode_next = M_STR;
                        "/":  mode_next = M_SLASH;
                        ".":  mode_next = M_DOTP;
                        8'h5C: mode_next = M_BSL;
                        "<", ">", "!": mode_next = M_CMP;
                        8'h7C: mode_next = M_BAR;
                        8'h26: mode_next = M_AMP;
                        "=":  mode_next = M_EQ;
                        default:
                        begin
                            if (is_dig)
                            begin
                                mode_next = M_NUM;
                                dot_next  = 1'b0;
                            end
                            else if (is_let)
                            begin
                                mode_next   = M_WORD;
                                prefix_next = KW_BITS'(c);
                            end
                            else
                            begin
                                p2_v      = 1'b1;
                                p2        = mk_tok(K_END, ST_STRAY, line_reg, col_reg, '0);
                                mode_next = M_DONE;
                            end
                        end
                    endcase
                    if (p2_v && p2.status == ST_OK)
                    begin
                        nl_next = (p2.kind == K_NEWLINE);
                    end
                end
                if (mode_next != M_DONE)
                begin
                    if (c == 8'h0A)
                    begin
                        line_next = sat_inc(line_reg);
                        col_next  = COUNT_BITS'(1);
                    end
                    else
                    begin
                        col_next = sat_inc(col_reg);
                    end
                end
            end
        end
        push.count  = 2'(p1_v) + 2'(p2_v);
        push.first  = p1_v ? p1 : p2;
        push.second = p2;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= M_IDLE;
            line_reg   <= COUNT_BITS'(1);
            col_reg    <= COUNT_BITS'(1);
            sline_reg  <= COUNT_BITS'(1);
            scol_reg   <= COUNT_BITS'(1);
            len_reg    <= '0;
            prefix_reg <= '0;
            dot_reg    <= 1'b0;
            star_reg   <= 1'b0;
            nl_reg     <= 1'b0;
        end
        else
        begin
            mode_reg   <= mode_next;
            line_reg   <= line_next;
            col_reg    <= col_next;
            sline_reg  <= sline_next;
            scol_reg   <= scol_next;
            len_reg    <= len_next;
            prefix_reg <= prefix_next;
            dot_reg    <= dot_next;
            star_reg   <= star_next;
            nl_reg     <= nl_next;
        end
    end

endmodule

>>> rtl/core/slt_queue.sv
// Result queue: takes up to two tokens per cycle, hands out one per cycle while out_ready is high.
// Depends on slt_pkg.
module slt_queue
    import slt_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  push_t  push,
    output logic   room,
    output logic   out_valid,
    input  logic   out_ready,
    output entry_t out_entry
);

    localparam int PTR_BITS = $clog2(QUEUE_DEPTH);

    entry_t                mem_reg [QUEUE_DEPTH];
    logic [PTR_BITS-1:0]   wr_reg, wr_next, rd_reg, rd_next;
    logic [PTR_BITS:0]     level_reg, level_next;
    logic                  pop;

    assign out_valid = (level_reg != '0);
    assign out_entry = mem_reg[rd_reg];
    assign room      = (level_reg <= (PTR_BITS + 1)'(QUEUE_DEPTH - 2));
    assign pop       = out_valid && out_ready;

    always_comb
    begin
        wr_next    = wr_reg + PTR_BITS'(push.count);
        rd_next    = rd_reg + PTR_BITS'(pop);
        level_next = level_reg + (PTR_BITS + 1)'(push.count) - (PTR_BITS + 1)'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            mem_reg[wr_reg] <= '{tok: push.first, last: (push.count == 2'd1)};
        end
        if (push.count == 2'd2)
        begin
            mem_reg[wr_reg + 1'b1] <= '{tok: push.second, last: 1'b1};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            level_reg <= '0;
        end
        else
        begin
            wr_reg    <= wr_next;
            rd_reg    <= rd_next;
            level_reg <= level_next;
        end
    end

endmodule

>>> rtl/core/source_token_lexer.sv
// Top level of the source token lexer: byte stream in, token stream out.
// Depends on slt_pkg, slt_lexer and slt_queue.
//
// Input channel s_axis: one source byte per item in tdata, tlast marks the
// end of source (byte then ignored). Output channel m_axis: one token per
// item; tlast marks the last token caused by one input item.
// Each accepted byte updates the lexer state in the same cycle and writes
// zero, one or two tokens into a four-entry result queue, from which they
// are handed out on m_axis in order.
// Throughput: one byte per cycle while the queue has room for two tokens;
// a byte that yields two tokens needs two output transfers, so the output port
// sets the sustained rate when tokens come densely.
// When the receiver stalls, the queue fills and s_axis_tready drops once
// fewer than two entries are free; no token is lost.
// After an error token or the end token no more tokens appear until reset.
// Reset (rst_n low, asynchronous) empties the queue and returns the lexer
// to line 1, column 1.
module source_token_lexer
    import slt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] char_code
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // [5:0] kind, [8:6] status, [24:9] line,
                                        // [40:25] column, [56:41] length, zeros
    output logic        m_axis_tlast
);

    push_t  push;
    entry_t head;
    logic   accept;

    assign accept = s_axis_tvalid && s_axis_tready;

    slt_lexer u_lexer (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .char_code    (s_axis_tdata),
        .end_of_input (s_axis_tlast),
        .push         (push)
    );

    slt_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room      (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_entry (head)
    );

    assign m_axis_tdata = {7'd0, head.tok.length, head.tok.column, head.tok.line,
                           head.tok.status, head.tok.kind};
    assign m_axis_tlast = head.last;

`ifndef SYNTHESIS
    a_no_push_without_accept: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |-> push.count == 2'd0)
        else $error("tokens produced without an accepted item");
    a_error_is_end: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[8:6] != ST_OK |-> m_axis_tdata[5:0] == K_END)
        else $error("error token without end kind");
    a_pair_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        push.count == 2'd2 |-> push.first.status == ST_OK)
        else $error("error token followed by another token");
`endif

endmodule

>>> bench/testbench.sv
// Self-checking testbench for source_token_lexer: byte stream in, token stream out.
// Depends on slt_pkg for token kinds and status codes; predicts tokens internally.
`timescale 1ns / 100ps

module testbench;
    import slt_pkg::*;

    localparam int LIMIT = 100000;
    localparam int RANDOM_ITEMS = 1200;
    localparam int HOLD_CYCLES = 300;

    typedef enum int {
        LX_IDLE, LX_WORD, LX_NUM, LX_FRAC, LX_DOTP, LX_STR, LX_SLASH, LX_LCOMM,
        LX_BCOMM, LX_CMP, LX_BAR, LX_AMP, LX_EQ, LX_BSL, LX_DONE
    } lx_mode_e;

    typedef struct {
        logic [5:0]  kind;
        logic [2:0]  status;
        logic [15:0] line;
        logic [15:0] column;
        logic [15:0] length;
        logic        last;
    } token_t;

    typedef struct {
        byte unsigned c;
        bit           eoi;
        bit           typed;
        token_t       tok;
    } row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'd0;
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [63:0] m_axis_tdata;
    logic        m_axis_tlast;

    source_token_lexer i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    token_t token_q[$];
    int     errors = 0;
    int     cycles = 0;
    int     sent = 0;
    int     idle_pct = 0;
    int     stall_pct = 0;
    bit     hold_req = 1'b0;
    bit     hold_done = 1'b0;
    int     hold_left = 0;

    lx_mode_e    mode;
    logic [15:0] cur_line, cur_col, tok_line, tok_col, tok_len;
    string       word_text;
    bit          seen_dot, seen_star, last_nl;
    int          step_n;

    string keywords[23] = '{
        "array", "assert", "bool", "else", "false", "float", "fn", "if",
        "image", "int", "let", "print", "read", "return", "show", "struct",
        "sum", "then", "time", "to", "true", "void", "write"
    };
    string operators[24] = '{
        "+", "-", "*", "%", "<", "<=", ">", ">=", "!", "!=", "=", "==", "||",
        "&&", "/", ".", ":", ",", "{", "}", "(", ")", "[", "]"
    };

    function automatic logic [15:0] sat16(input logic [15:0] v);
        return (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

    function automatic void push_token(input logic [5:0] kind, input logic [2:0] st,
                                       input logic [15:0] ln, input logic [15:0] col,
                                       input logic [15:0] len);
        token_t t;
        if (step_n >= 2)
            return;
        t.kind = kind;
        t.status = st;
        t.line = ln;
        t.column = col;
        t.length = len;
        t.last = 1'b0;
        token_q.push_back(t);
        step_n++;
        if (st == ST_OK && kind != K_END)
            last_nl = (kind == K_NEWLINE);
    endfunction

    function automatic void flush_token(input logic [5:0] kind);
        push_token(kind, ST_OK, tok_line, tok_col, tok_len);
        mode = LX_IDLE;
    endfunction

    function automatic void raise_error(input logic [2:0] st, input logic [15:0] ln,
                                        input logic [15:0] col);
        push_token(K_END, st, ln, col, 16'd0);
        mode = LX_DONE;
    endfunction

    function automatic logic [5:0] classify_word();
        if (tok_len <= 6)
            for (int i = 0; i < 23; i++)
                if (keywords[i].len() == tok_len && keywords[i] == word_text)
                    return 6'(i);
        return K_IDENT;
    endfunction

    function automatic bit is_digit(input byte unsigned c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit is_letter(input byte unsigned c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic void open_token(input byte unsigned c);
        tok_line = cur_line;
        tok_col = cur_col;
        tok_len = 16'd1;
        mode = LX_IDLE;
        case (c)
            "\n": if (!last_nl) push_token(K_NEWLINE, ST_OK, cur_line, cur_col, 16'd1);
            " ": ;
            ":": push_token(K_COLON, ST_OK, cur_line, cur_col, 16'd1);
            ",": push_token(K_COMMA, ST_OK, cur_line, cur_col, 16'd1);
            "{": push_token(K_LBRACE, ST_OK, cur_line, cur_col, 16'd1);
            "}": push_token(K_RBRACE, ST_OK, cur_line, cur_col, 16'd1);
            "(": push_token(K_LPAREN, ST_OK, cur_line, cur_col, 16'd1);
            ")": push_token(K_RPAREN, ST_OK, cur_line, cur_col, 16'd1);
            "[": push_token(K_LBRACK, ST_OK, cur_line, cur_col, 16'd1);
            "]": push_token(K_RBRACK, ST_OK, cur_line, cur_col, 16'd1);
            "+", "-", "*", "%": push_token(K_OP, ST_OK, cur_line, cur_col, 16'd1);
            "\"": mode = LX_STR;
            "/": mode = LX_SLASH;
            ".": mode = LX_DOTP;
            "\\": mode = LX_BSL;
            "<", ">", "!": mode = LX_CMP;
            "|": mode = LX_BAR;
            "&": mode = LX_AMP;
            "=": mode = LX_EQ;
            default:
            begin
                if (is_digit(c))
                begin
                    mode = LX_NUM;
                    seen_dot = 1'b0;
                end
                else if (is_letter(c))
                begin
                    mode = LX_WORD;
                    word_text = string'(c);
                end
                else
                    raise_error(ST_STRAY, cur_line, cur_col);
            end
        endcase
    endfunction

    function automatic void lexer_reset();
        mode = LX_IDLE;
        cur_line = 16'd1;
        cur_col = 16'd1;
        tok_line = 16'd1;
        tok_col = 16'd1;
        tok_len = 16'd0;
        word_text = "";
        seen_dot = 1'b0;
        seen_star = 1'b0;
        last_nl = 1'b0;
    endfunction

    function automatic int lex_byte(input byte unsigned c, input bit eoi);
        step_n = 0;
        if (mode == LX_DONE)
            return 0;
        if (eoi)
        begin
            case (mode)
                LX_WORD: flush_token(classify_word());
                LX_NUM: flush_token(seen_dot ? K_FLOAT : K_INT);
                LX_FRAC: flush_token(K_FLOAT);
                LX_DOTP: flush_token(K_DOT);
                LX_SLASH, LX_CMP: flush_token(K_OP);
                LX_EQ: flush_token(K_EQUALS);
                LX_STR: raise_error(ST_OPEN_STR, tok_line, tok_col);
                LX_BCOMM: raise_error(ST_OPEN_CMT, tok_line, tok_col);
                LX_BAR, LX_AMP, LX_BSL: raise_error(ST_STRAY, tok_line, tok_col);
                default: ;
            endcase
            if (mode != LX_DONE)
                push_token(K_END, ST_OK, cur_line, cur_col, 16'd0);
            mode = LX_DONE;
        end
        else if ((c < 32 || c > 126) && c != "\n")
            raise_error(ST_BAD_BYTE, cur_line, cur_col);
        else
        begin
            case (mode)
                LX_WORD:
                    if (is_letter(c) || is_digit(c) || c == "_")
                    begin
                        if (tok_len < 6)
                            word_text = {word_text, string'(c)};
                        tok_len = sat16(tok_len);
                    end
                    else
                    begin
                        flush_token(classify_word());
                        open_token(c);
                    end
                LX_NUM:
                    if (is_digit(c))
                        tok_len = sat16(tok_len);
                    else if (c == ".")
                    begin
                        tok_len = sat16(tok_len);
                        if (seen_dot)
                            flush_token(K_FLOAT);
                        else
                            seen_dot = 1'b1;
                    end
                    else
                    begin
                        flush_token(seen_dot ? K_FLOAT : K_INT);
                        open_token(c);
                    end
                LX_FRAC:
                    if (is_digit(c))
                        tok_len = sat16(tok_len);
                    else
                    begin
                        flush_token(K_FLOAT);
                        open_token(c);
                    end
                LX_DOTP:
                    if (is_digit(c))
                    begin
                        mode = LX_FRAC;
                        tok_len = 16'd2;
                    end
                    else
                    begin
                        flush_token(K_DOT);
                        open_token(c);
                    end
                LX_STR:
                    if (c == "\n")
                        raise_error(ST_OPEN_STR, tok_line, tok_col);
                    else
                    begin
                        tok_len = sat16(tok_len);
                        if (c == "\"")
                            flush_token(K_STRING);
                    end
                LX_SLASH:
                    if (c == "/")
                        mode = LX_LCOMM;
                    else if (c == "*")
                    begin
                        mode = LX_BCOMM;
                        seen_star = 1'b0;
                    end
                    else
                    begin
                        flush_token(K_OP);
                        open_token(c);
                    end
                LX_LCOMM:
                    if (c == "\n")
                        open_token(c);
                LX_BCOMM:
                    if (c == "/" && seen_star)
                        mode = LX_IDLE;
                    else
                        seen_star = (c == "*");
                LX_CMP, LX_EQ:
                    if (c == "=")
                    begin
                        tok_len = 16'd2;
                        flush_token(K_OP);
                    end
                    else
                    begin
                        flush_token(mode == LX_EQ ? K_EQUALS : K_OP);
                        open_token(c);
                    end
                LX_BAR, LX_AMP:
                    if (c == ((mode == LX_BAR) ? "|" : "&"))
                    begin
                        tok_len = 16'd2;
                        flush_token(K_OP);
                    end
                    else
                        raise_error(ST_STRAY, tok_line, tok_col);
                LX_BSL:
                    if (c == "\n")
                        mode = LX_IDLE;
                    else
                        raise_error(ST_STRAY, tok_line, tok_col);
                default:
                    open_token(c);
            endcase
            if (mode != LX_DONE)
            begin
                if (c == "\n")
                begin
                    cur_line = sat16(cur_line);
                    cur_col = 16'd1;
                end
                else
                    cur_col = sat16(cur_col);
            end
        end
        if (step_n > 0)
            token_q[$].last = 1'b1;
        return step_n;
    endfunction

    task automatic report_mismatch(input string what, input longint want, input longint got);
        $display("mismatch %s: expected %0d, got %0d at cycle %0d", what, want, got, cycles);
        errors++;
    endtask

    always @(posedge clk)
    begin
        token_t t;
        if (m_axis_tvalid && m_axis_tready)
        begin
            if (token_q.size() == 0)
                report_mismatch("unexpected token, kind", -1, m_axis_tdata[5:0]);
            else
            begin
                t = token_q.pop_front();
                if (m_axis_tdata[5:0] !== t.kind)
                    report_mismatch("kind", t.kind, m_axis_tdata[5:0]);
                if (m_axis_tdata[8:6] !== t.status)
                    report_mismatch("status", t.status, m_axis_tdata[8:6]);
                if (m_axis_tdata[24:9] !== t.line)
                    report_mismatch("line", t.line, m_axis_tdata[24:9]);
                if (m_axis_tdata[40:25] !== t.column)
                    report_mismatch("column", t.column, m_axis_tdata[40:25]);
                if (m_axis_tdata[56:41] !== t.length)
                    report_mismatch("length", t.length, m_axis_tdata[56:41]);
                if (m_axis_tdata[63:57] !== 7'd0)
                    report_mismatch("padding", 0, m_axis_tdata[63:57]);
                if (m_axis_tlast !== t.last)
                    report_mismatch("tlast", t.last, m_axis_tlast);
            end
        end
    end

    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end
        else if (hold_req)
        begin
            hold_req <= 1'b0;
            hold_left <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("[source_token_lexer] ERROR");
            $finish;
        end
    end

    task automatic send_byte(input byte unsigned c, input bit eoi);
        int n;
        while ($urandom_range(99) < idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= c;
        s_axis_tlast <= eoi;
        do
            @(posedge clk);
        while (!(s_axis_tvalid && s_axis_tready));
        n = lex_byte(c, eoi);
        sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i], 1'b0);
    endtask

    function automatic string rand_chars(input int n, input bit no_quote, input bit no_slash);
        string s;
        byte unsigned c;
        s = "";
        for (int i = 0; i < n; i++)
        begin
            c = $urandom_range(32, 126);
            if ((no_quote && c == "\"") || (no_slash && c == "/"))
                c = "x";
            s = {s, string'(c)};
        end
        return s;
    endfunction

    function automatic string rand_digits(input int n);
        string s;
        s = "";
        for (int i = 0; i < n; i++)
            s = {s, string'(byte'($urandom_range("0", "9")))};
        return s;
    endfunction

    function automatic string make_fragment();
        string s;
        byte unsigned c;
        case ($urandom_range(13))
            0, 1: s = keywords[$urandom_range(22)];
            2:
            begin
                s = keywords[$urandom_range(22)];
                s = ($urandom_range(1)) ? {s, "s_1"} : s.substr(0, s.len() - 2);
            end
            3, 4:
            begin
                c = $urandom_range(1) ? $urandom_range("a", "z") : $urandom_range("A", "Z");
                s = string'(c);
                repeat ($urandom_range(9))
                begin
                    case ($urandom_range(3))
                        0: c = $urandom_range("a", "z");
                        1: c = $urandom_range("A", "Z");
                        2: c = $urandom_range("0", "9");
                        default: c = "_";
                    endcase
                    s = {s, string'(c)};
                end
            end
            5:
            begin
                s = rand_digits($urandom_range(1, 5));
                if ($urandom_range(1))
                    s = {s, ".", rand_digits($urandom_range(3))};
                if ($urandom_range(2) == 0)
                    s = {s, "."};
            end
            6: s = {".", rand_digits($urandom_range(1, 4)), $urandom_range(1) ? "." : ""};
            7: s = {"\"", rand_chars($urandom_range(8), 1'b1, 1'b0), "\""};
            8, 9: s = operators[$urandom_range(23)];
            10: s = {"//", rand_chars($urandom_range(10), 1'b0, 1'b0), "\n"};
            11:
            begin
                s = "/*";
                repeat ($urandom_range(10))
                    s = {s, ($urandom_range(5) == 0) ? "\n" : rand_chars(1, 1'b0, 1'b1)};
                s = {s, "*/"};
            end
            12: s = $urandom_range(1) ? "\\\n" : "\n\n";
            default: s = "\n";
        endcase
        return s;
    endfunction

    function automatic row_t r(input byte unsigned c);
        row_t x;
        x.c = c;
        x.eoi = 1'b0;
        x.typed = 1'b0;
        return x;
    endfunction

    row_t directed[$];

    initial
    begin
        int    n;
        int    kind;
        row_t  first;
        string s;

        lexer_reset();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        first = r("(");
        first.typed = 1'b1;
        first.tok = '{K_LPAREN, ST_OK, 16'd1, 16'd1, 16'd1, 1'b1};
        directed = '{first, r("a"), r("_"), r("9"), r("1"), r("."), r("2"), r("."),
                     r("."), r("5"), r("."), r("\n"), r("\n"), r("\""), r("q"), r("\""),
                     r("/"), r("*"), r("*"), r("\n"), r("*"), r("/"), r("<"), r("="),
                     r("|"), r("|"), r("\\"), r("\n"), r("&"), r("&"), r("!")};
        foreach (directed[i])
        begin
            if (directed[i].typed)
            begin
                while (!(s_axis_tvalid && s_axis_tready))
                begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= directed[i].c;
                    s_axis_tlast <= directed[i].eoi;
                    @(posedge clk);
                end
                n = lex_byte(directed[i].c, directed[i].eoi);
                repeat (n) void'(token_q.pop_back());
                token_q.push_back(directed[i].tok);
                sent++;
            end
            else
                send_byte(directed[i].c, directed[i].eoi);
        end
        send_text(" ");

        while (sent < RANDOM_ITEMS)
        begin
            case ((sent / 150) % 4)
                0: begin idle_pct = 0; stall_pct = 0; end
                1: begin idle_pct = 61; stall_pct = 0; end
                2: begin idle_pct = 0; stall_pct = 61; end
                default: begin idle_pct = 16; stall_pct = 16; end
            endcase
            if (sent >= 600 && !hold_done && hold_left == 0 && !hold_req)
            begin
                hold_req = 1'b1;
                hold_done = 1'b1;
                idle_pct = 0;
                repeat (40) send_text("(),");
            end
            s = make_fragment();
            if ($urandom_range(1))
                s = {s, " "};
            send_text(s);
        end

        idle_pct = 16;
        stall_pct = 16;

        kind = $urandom_range(5);
        case (kind)
            0: send_byte($urandom_range(1) ? 8'hFF : 8'h80 | 8'($urandom_range(127)), 1'b0);
            1: send_byte($urandom_range(1) ? "#" : ";", 1'b0);
            2: begin send_text("\"ab"); send_byte(8'h00, 1'b1); end
            3: begin send_text("/* c"); send_byte(8'hA5, 1'b1); end
            4: send_text("|x");
            default: begin send_text("abc"); send_byte(8'($urandom), 1'b1); end
        endcase
        // the block is silent now; these only toggle the remaining input bits
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b1);
        send_byte(8'($urandom), 1'($urandom));
        s_axis_tvalid <= 1'b0;

        while (token_q.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("[source_token_lexer] OK");
        else
            $display("[source_token_lexer] ERROR");
        $finish;
    end

endmodule
